[rtl/core/maze_wall_follower_mapper_macros.svh]
// Assertion macros for the maze wall-follower mapper.
// Included by the RTL files that carry concurrent assertions.
`ifndef MAZE_WALL_FOLLOWER_MAPPER_MACROS_SVH
`define MAZE_WALL_FOLLOWER_MAPPER_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define MWF_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define MWF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   `MWF_ASSERT_RST(label, clk, rst, (ante) |-> (cons), msg)
`else
`define MWF_ASSERT_RST(label, clk, rst, prop, msg)
`define MWF_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/mwf_pkg.sv]
// Shared types, codes and grid helpers for the maze wall-follower mapper.
// No dependencies.
`default_nettype none
package mwf_pkg;

   localparam int GRID_SIZE_DEF = 9;
   localparam int CELL_W        = 5;   // bit 4 visited, bits 0..3 walls N E S W

   localparam logic [15:0] THRESH_RST  = 16'd100;
   localparam logic [3:0]  START_X_RST = 4'd1;
   localparam logic [3:0]  START_Y_RST = 4'd1;
   localparam logic [1:0]  START_H_RST = 2'd0;

   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_PLAN    = 2'd1,
      OP_APPLY   = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CMD_NONE = 3'd0,
      CMD_F    = 3'd1,
      CMD_RF   = 3'd2,
      CMD_LF   = 3'd3,
      CMD_RR   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      REG_THRESH  = 2'd0,
      REG_START_X = 2'd1,
      REG_START_Y = 2'd2,
      REG_START_H = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_START, ST_IDLE,
      ST_P_RDC, ST_P_WRC, ST_P_RDN, ST_P_WRN, ST_P_DEC,
      ST_A_RDC, ST_A_CHK, ST_A_WRT, ST_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] left_mm;
      logic [15:0] front_mm;
      logic [15:0] right_mm;
      logic [1:0]  turn_quarters;
      logic        move_forward;
   } req_type;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] pos_x;
      logic [3:0] pos_y;
      logic [1:0] heading_out;
      logic [6:0] visited_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] block_thresh_mm;
      logic [3:0]  start_x;
      logic [3:0]  start_y;
      logic [1:0]  start_heading;
   } cfg_type;

   // Corner cells and the edge cells adjacent to them are cut out of the grid.
   function automatic logic is_removed(input logic [4:0] x, input logic [4:0] y,
                                       input logic [4:0] m);
      logic xe, ye;
      xe = (x == 5'd0) || (x == m);
      ye = (y == 5'd0) || (y == m);
      return (xe && ye) || (xe && (y == 5'd1 || y == m - 5'd1))
             || (ye && (x == 5'd1 || x == m - 5'd1));
   endfunction

   function automatic logic open_cell(input logic [4:0] x, input logic [4:0] y,
                                      input logic [4:0] g);
      return (x < g) && (y < g) && !is_removed(x, y, g - 5'd1);
   endfunction

endpackage
`default_nettype wire

[rtl/core/mwf_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mwf_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 81
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[rtl/core/mwf_csr.sv]
// Configuration registers behind the APB-style port.
// Depends on mwf_pkg.
`default_nettype none
module mwf_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready,
   output mwf_pkg::cfg_type      cfg
);
   mwf_pkg::cfg_type       cfg_ff, cfg_in;
   mwf_pkg::reg_index_type idx;

   assign idx    = mwf_pkg::reg_index_type'(paddr[3:2]);
   assign pready = 1'b1;

   // Decode writes
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (idx)
            mwf_pkg::REG_THRESH:  cfg_in.block_thresh_mm = pwdata[15:0];
            mwf_pkg::REG_START_X: cfg_in.start_x         = pwdata[3:0];
            mwf_pkg::REG_START_Y: cfg_in.start_y         = pwdata[3:0];
            mwf_pkg::REG_START_H: cfg_in.start_heading   = pwdata[1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_thresh_mm <= mwf_pkg::THRESH_RST;
         cfg_ff.start_x         <= mwf_pkg::START_X_RST;
         cfg_ff.start_y         <= mwf_pkg::START_Y_RST;
         cfg_ff.start_heading   <= mwf_pkg::START_H_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         mwf_pkg::REG_THRESH:  prdata = {16'd0, cfg_ff.block_thresh_mm};
         mwf_pkg::REG_START_X: prdata = {28'd0, cfg_ff.start_x};
         mwf_pkg::REG_START_Y: prdata = {28'd0, cfg_ff.start_y};
         mwf_pkg::REG_START_H: prdata = {30'd0, cfg_ff.start_heading};
      endcase
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

[rtl/core/mwf_core.sv]
// Sequencer and datapath: read-modify-write of the cell map, pose and count.
// Depends on mwf_pkg, mwf_ram and the assertion macro header.
`default_nettype none
`include "maze_wall_follower_mapper_macros.svh"
module mwf_core #(
   parameter int GRID_SIZE = mwf_pkg::GRID_SIZE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mwf_pkg::cfg_type cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mwf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mwf_pkg::rsp_type      rsp_data
);
   localparam int CELLS  = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CW     = mwf_pkg::CELL_W;
   localparam logic [4:0] GRID_G = 5'(GRID_SIZE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   mwf_pkg::state_type state_ff, state_in;
   logic [3:0]        x_ff, x_in, y_ff, y_in;
   logic [1:0]        h_ff, h_in, dir_ff, dir_in;
   logic [6:0]        vis_ff, vis_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [3:0]        sens_ff, sens_in, add_ff, add_in, walls_ff, walls_in;
   logic [3:0]        visn_ff, visn_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic              emit_ff, emit_in, fwd_ff, fwd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mwf_pkg::rsp_type  rsp_ff, rsp_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [CW-1:0]     ram_wdata, ram_rdata;

   logic [4:0]        nx [4];
   logic [4:0]        ny [4];
   logic [3:0]        n_on, n_open;
   logic [ADDR_W-1:0] n_addr [4];
   logic [ADDR_W-1:0] cur_addr;
   logic              cur_on, cur_open;
   logic [9:0]        cur_lin;
   logic [9:0]        n_lin [4];
   logic [3:0]        ok0, ok1;
   logic [1:0]        pick;
   logic              found;
   logic [2:0]        cmd_dec;
   logic [3:0]        walls_new;

   mwf_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Current cell and its four neighbors
   always_comb begin
      cur_on   = ({1'b0, x_ff} < GRID_G) && ({1'b0, y_ff} < GRID_G);
      cur_open = mwf_pkg::open_cell({1'b0, x_ff}, {1'b0, y_ff}, GRID_G);
      cur_lin  = 10'(y_ff) * 10'(GRID_SIZE) + 10'(x_ff);
      cur_addr = cur_lin[ADDR_W-1:0];
      for (int d = 0; d < 4; d++) begin
         nx[d] = {1'b0, x_ff} + ((d == 1) ? 5'd1 : 5'd0) - ((d == 3) ? 5'd1 : 5'd0);
         ny[d] = {1'b0, y_ff} + ((d == 0) ? 5'd1 : 5'd0) - ((d == 2) ? 5'd1 : 5'd0);
         n_on[d]   = (nx[d] < GRID_G) && (ny[d] < GRID_G);
         n_open[d] = mwf_pkg::open_cell(nx[d], ny[d], GRID_G);
         n_lin[d]  = 10'(ny[d]) * 10'(GRID_SIZE) + 10'(nx[d]);
         n_addr[d] = n_lin[d][ADDR_W-1:0];
      end
   end

   // Right-hand choice: right, forward, left, back; unvisited first
   always_comb begin
      logic [1:0] c;
      c = '0;
      for (int i = 0; i < 4; i++) begin
         unique case (i)
            0: c = h_ff + 2'd1;
            1: c = h_ff;
            2: c = h_ff + 2'd3;
            default: c = h_ff + 2'd2;
         endcase
         ok1[i] = n_open[c] && !walls_ff[c];
         ok0[i] = ok1[i] && !visn_ff[c];
      end
      found = 1'b1;
      priority if (ok0[0]) pick = h_ff + 2'd1;
      else if (ok0[1])     pick = h_ff;
      else if (ok0[2])     pick = h_ff + 2'd3;
      else if (ok0[3])     pick = h_ff + 2'd2;
      else if (ok1[0])     pick = h_ff + 2'd1;
      else if (ok1[1])     pick = h_ff;
      else if (ok1[2])     pick = h_ff + 2'd3;
      else if (ok1[3])     pick = h_ff + 2'd2;
      else begin
         pick  = h_ff;
         found = 1'b0;
      end
      priority if (!found || walls_ff[pick]) cmd_dec = mwf_pkg::CMD_NONE;
      else if (pick == h_ff)                 cmd_dec = mwf_pkg::CMD_F;
      else if (pick == h_ff + 2'd1)          cmd_dec = mwf_pkg::CMD_RF;
      else if (pick == h_ff + 2'd3)          cmd_dec = mwf_pkg::CMD_LF;
      else                                   cmd_dec = mwf_pkg::CMD_RR;
   end

   assign walls_new = ram_rdata[3:0] | add_ff;

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      x_in = x_ff;  y_in = y_ff;  h_in = h_ff;  dir_in = dir_ff;
      vis_in       = vis_ff;
      clr_in       = clr_ff;
      sens_in      = sens_ff;
      add_in       = add_ff;
      walls_in     = walls_ff;
      visn_in      = visn_ff;
      cmd_in       = cmd_ff;
      emit_in      = emit_ff;
      fwd_in       = fwd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_addr     = cur_addr;
      ram_wdata    = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         // Sweep the map to zero
         mwf_pkg::ST_CLR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            if (clr_ff == LAST_ADDR) begin
               state_in = mwf_pkg::ST_START;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         // Mark the start cell
         mwf_pkg::ST_START: begin
            ram_we    = cur_open;
            ram_wdata = CW'(5'b10000);
            vis_in    = cur_open ? 7'd1 : 7'd0;
            state_in  = emit_ff ? mwf_pkg::ST_FIN : mwf_pkg::ST_IDLE;
         end
         mwf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               emit_in = 1'b1;
               cmd_in  = mwf_pkg::CMD_NONE;
               unique case (mwf_pkg::opcode_type'(req_data.opcode))
                  mwf_pkg::OP_RESTART: begin
                     x_in     = cfg.start_x;
                     y_in     = cfg.start_y;
                     h_in     = cfg.start_heading;
                     clr_in   = '0;
                     vis_in   = '0;
                     state_in = mwf_pkg::ST_CLR;
                  end
                  mwf_pkg::OP_PLAN: begin
                     sens_in = '0;
                     if (req_data.left_mm != 16'd0
                         && req_data.left_mm <= cfg.block_thresh_mm)
                        sens_in[h_ff + 2'd3] = 1'b1;
                     if (req_data.front_mm != 16'd0
                         && req_data.front_mm <= cfg.block_thresh_mm)
                        sens_in[h_ff] = 1'b1;
                     if (req_data.right_mm != 16'd0
                         && req_data.right_mm <= cfg.block_thresh_mm)
                        sens_in[h_ff + 2'd1] = 1'b1;
                     state_in = mwf_pkg::ST_P_RDC;
                  end
                  mwf_pkg::OP_APPLY: begin
                     h_in     = h_ff + req_data.turn_quarters;
                     fwd_in   = req_data.move_forward;
                     state_in = mwf_pkg::ST_A_RDC;
                  end
                  mwf_pkg::OP_NOP: state_in = mwf_pkg::ST_FIN;
               endcase
            end
         end
         // Plan: read current cell, fold in new walls
         mwf_pkg::ST_P_RDC: begin
            add_in   = sens_ff | ~n_open;
            state_in = cur_on ? mwf_pkg::ST_P_WRC : mwf_pkg::ST_FIN;
         end
         mwf_pkg::ST_P_WRC: begin
            ram_we    = 1'b1;
            ram_wdata = {ram_rdata[4], walls_new};
            walls_in  = walls_new;
            dir_in    = 2'd0;
            state_in  = mwf_pkg::ST_P_RDN;
         end
         // Plan: mirror walls into each neighbor, pick up visited marks
         mwf_pkg::ST_P_RDN: begin
            ram_addr = n_addr[dir_ff];
            state_in = mwf_pkg::ST_P_WRN;
         end
         mwf_pkg::ST_P_WRN: begin
            ram_addr  = n_addr[dir_ff];
            ram_we    = n_on[dir_ff] && add_ff[dir_ff];
            ram_wdata = ram_rdata | CW'(4'b0001 << (dir_ff + 2'd2));
            visn_in[dir_ff] = n_on[dir_ff] && ram_rdata[4];
            dir_in    = dir_ff + 2'd1;
            state_in  = (dir_ff == 2'd3) ? mwf_pkg::ST_P_DEC : mwf_pkg::ST_P_RDN;
         end
         mwf_pkg::ST_P_DEC: begin
            cmd_in   = cmd_dec;
            state_in = mwf_pkg::ST_FIN;
         end
         // Apply: check the way ahead, then move and mark
         mwf_pkg::ST_A_RDC: begin
            state_in = (fwd_ff && cur_on && n_open[h_ff]) ? mwf_pkg::ST_A_CHK
                                                          : mwf_pkg::ST_FIN;
         end
         mwf_pkg::ST_A_CHK: begin
            ram_addr = n_addr[h_ff];
            state_in = ram_rdata[h_ff] ? mwf_pkg::ST_FIN : mwf_pkg::ST_A_WRT;
         end
         mwf_pkg::ST_A_WRT: begin
            ram_addr  = n_addr[h_ff];
            ram_we    = !ram_rdata[4];
            ram_wdata = {1'b1, ram_rdata[3:0]};
            if (!ram_rdata[4] && vis_ff != 7'd127) begin
               vis_in = vis_ff + 7'd1;
            end
            x_in     = nx[h_ff][3:0];
            y_in     = ny[h_ff][3:0];
            state_in = mwf_pkg::ST_FIN;
         end
         // Hand the result to the output register
         mwf_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.command        = cmd_ff;
               rsp_in.pos_x          = x_ff;
               rsp_in.pos_y          = y_ff;
               rsp_in.heading_out    = h_ff;
               rsp_in.visited_count  = vis_ff;
               emit_in               = 1'b0;
               state_in              = mwf_pkg::ST_IDLE;
            end
         end
         default: state_in = mwf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwf_pkg::ST_CLR;
         x_ff         <= mwf_pkg::START_X_RST;
         y_ff         <= mwf_pkg::START_Y_RST;
         h_ff         <= mwf_pkg::START_H_RST;
         vis_ff       <= '0;
         clr_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         h_ff         <= h_in;
         vis_ff       <= vis_in;
         clr_ff       <= clr_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff   <= dir_in;
      sens_ff  <= sens_in;
      add_ff   <= add_in;
      walls_ff <= walls_in;
      visn_ff  <= visn_in;
      cmd_ff   <= cmd_in;
      fwd_ff   <= fwd_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MWF_ASSERT_IMP(a_no_write_idle, clock, reset, state_ff == mwf_pkg::ST_IDLE, !ram_we, "map written while idle")
   `MWF_ASSERT_RST(a_count_stable, clock, reset, (state_ff != mwf_pkg::ST_IDLE && state_ff != mwf_pkg::ST_START && state_ff != mwf_pkg::ST_A_WRT) |=> $stable(vis_ff), "visited count moved outside update states")
   `MWF_ASSERT_RST(a_fin_loads, clock, reset, (state_ff == mwf_pkg::ST_FIN) && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff, "finished item not presented")
endmodule
`default_nettype wire

[rtl/core/maze_wall_follower_mapper.sv]
// Top level of the maze wall-follower mapper: CSR block and map sequencer.
// Depends on mwf_pkg, mwf_csr, mwf_core (which holds the map RAM).
//
// One item at a time. A plan does a current-cell read-modify-write and one
// read-modify-write per neighbor through the single map RAM port, and skips
// all of them when the robot sits off the grid. A restart clears one RAM
// word per cycle. After reset the same clearing pass runs with req_ready
// low; CSR writes are taken throughout.
`default_nettype none
module maze_wall_follower_mapper #(
   parameter int GRID_SIZE = mwf_pkg::GRID_SIZE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mwf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mwf_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready
);
   mwf_pkg::cfg_type cfg;

   mwf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mwf_core #(.GRID_SIZE(GRID_SIZE)) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire
